[src/bfhc_pkg.sv]
// ----------------------------------------------------------------------------
// bfhc_pkg
// Types, codes and defaults shared by the flow hit counter table.
// ----------------------------------------------------------------------------
`default_nettype none

package bfhc_pkg;

   localparam int ENTRIES_DEFAULT = 64;
   localparam int USED_W          = 7;

   localparam logic [1:0] MODE_ADD   = 2'd0;
   localparam logic [1:0] MODE_HIT   = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;
   localparam logic [1:0] MODE_CLEAR = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_BEYOND    = 2'd3;

   typedef struct packed {
      logic [1:0]         mode;
      logic [7:0]         protocol;
      logic [7:0]         action;
      logic [7:0]         hook;
      logic [31:0]        src_addr;
      logic [31:0]        dst_addr;
      logic [15:0]        sport;
      logic [15:0]        dport;
      logic signed [7:0]  why;
      logic [31:0]        hits_init;
      logic [31:0]        now;
      logic [5:0]         slot;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [7:0]         out_protocol;
      logic [7:0]         out_action;
      logic [7:0]         out_hook;
      logic [31:0]        out_src_addr;
      logic [31:0]        out_dst_addr;
      logic [15:0]        out_sport;
      logic [15:0]        out_dport;
      logic signed [7:0]  out_why;
      logic [31:0]        out_hits;
      logic [31:0]        out_time;
      logic [USED_W-1:0]  used;
   } rsp_type;

   typedef struct packed {
      logic [7:0]         protocol;
      logic [7:0]         action;
      logic [7:0]         hook;
      logic [31:0]        src_addr;
      logic [31:0]        dst_addr;
      logic [15:0]        sport;
      logic [15:0]        dport;
      logic [7:0]         why;
      logic [31:0]        hits;
      logic [31:0]        stamp;
   } record_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic               shift;
      logic               cmp;
      logic [31:0]        now;
      record_type         key;
   } cell_ctl_type;

endpackage

`default_nettype wire

[src/bfhc_intf.sv]
// ----------------------------------------------------------------------------
// bfhc request and response channels
// Valid/ready channels carrying one request or one response.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfhc_req_if;
   import bfhc_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface bfhc_rsp_if;
   import bfhc_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/bfhc_cell.sv]
// ----------------------------------------------------------------------------
// bfhc_cell
// One table entry: holds a record, shifts from its newer neighbor on add,
// compares against the broadcast key and applies a hit update.
// ----------------------------------------------------------------------------
`default_nettype none

module bfhc_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bfhc_pkg::cell_ctl_type ctl,
   input  logic [CNT_W-1:0]      count,
   input  bfhc_pkg::record_type  prev_rec,
   input  logic                  upd,
   output bfhc_pkg::record_type  rec,
   output logic                  match
);
   import bfhc_pkg::*;

   record_type rec_ff, rec_in;
   logic       match_ff, match_in;
   logic       live, base, fwd, rev;

   always_comb begin
      live = (INDEX < int'(count));
      base = (rec_ff.protocol == ctl.key.protocol) && (rec_ff.action == ctl.key.action) &&
             (rec_ff.hook == ctl.key.hook) && (rec_ff.why == ctl.key.why);
      fwd  = (rec_ff.src_addr == ctl.key.src_addr) && (rec_ff.dst_addr == ctl.key.dst_addr) &&
             (rec_ff.sport == ctl.key.sport) && (rec_ff.dport == ctl.key.dport);
      rev  = (rec_ff.src_addr == ctl.key.dst_addr) && (rec_ff.dst_addr == ctl.key.src_addr) &&
             (rec_ff.sport == ctl.key.dport) && (rec_ff.dport == ctl.key.sport);
      match_in = ctl.cmp && live && base && (fwd || rev);

      rec_in = rec_ff;
      if (ctl.shift) begin
         rec_in = prev_rec;
      end else if (upd) begin
         rec_in.hits  = rec_ff.hits + 32'd1;
         rec_in.stamp = ctl.now;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign rec   = rec_ff;
   assign match = match_ff;

endmodule

`default_nettype wire

[src/bidirectional_flow_hit_counter.sv]
// ----------------------------------------------------------------------------
// bidirectional_flow_hit_counter
// Flow record table built as a chain of cells, newest record in cell 0.
// ----------------------------------------------------------------------------
// Steps: a hit passes through accept, parallel compare in every cell,
// priority select and update, and output load; add, read and clear skip
// the select step. One request is handled at a time; a new request is
// taken while the previous response still waits in the output register,
// and the next one stalls until that response leaves.
// Reset clears the entry count and control state; cell contents are kept.
// ----------------------------------------------------------------------------
`default_nettype none

module bidirectional_flow_hit_counter #(
   parameter int ENTRIES = bfhc_pkg::ENTRIES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   bfhc_req_if.sink   req_ch,
   bfhc_rsp_if.source rsp_ch
);
   import bfhc_pkg::*;

   localparam int CNT_W = $clog2(ENTRIES + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_SEL, ST_LOAD} state_type;

   state_type        state_ff;
   req_type          req_ff;
   logic [CNT_W-1:0] count_ff;
   logic [ENTRIES-1:0] sel_ff;
   logic [1:0]       status_ff;
   logic             has_rec_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   cell_ctl_type     ctl;
   record_type       new_rec;
   record_type       rec_w [ENTRIES];
   record_type       rd_rec;
   logic [ENTRIES-1:0] match_w, first_w, upd_w, slot_sel;
   logic             any_match, full, slot_ok, out_free;

   always_comb begin
      new_rec.protocol = req_ff.protocol;
      new_rec.action   = req_ff.action;
      new_rec.hook     = req_ff.hook;
      new_rec.src_addr = req_ff.src_addr;
      new_rec.dst_addr = req_ff.dst_addr;
      new_rec.sport    = req_ff.sport;
      new_rec.dport    = req_ff.dport;
      new_rec.why      = req_ff.why;
      new_rec.hits     = req_ff.hits_init;
      new_rec.stamp    = req_ff.now;

      full    = (int'(count_ff) >= ENTRIES);
      slot_ok = (int'(req_ff.slot) < int'(count_ff));

      ctl.shift = (state_ff == ST_EXEC) && (req_ff.mode == MODE_ADD) && !full;
      ctl.cmp   = (state_ff == ST_EXEC) && (req_ff.mode == MODE_HIT);
      ctl.now   = req_ff.now;
      ctl.key   = new_rec;

      any_match = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         first_w[i]  = match_w[i] && !any_match;
         any_match   = any_match || match_w[i];
         slot_sel[i] = (int'(req_ff.slot) == i);
      end
      upd_w = (state_ff == ST_SEL) ? first_w : '0;

      rd_rec = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (sel_ff[i]) begin
            rd_rec = record_type'(rd_rec | rec_w[i]);
         end
      end
      if (!has_rec_ff) begin
         rd_rec = '0;
      end

      out_free = !rsp_valid_ff || rsp_ch.ready;
   end

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      bfhc_cell #(.INDEX(g), .CNT_W(CNT_W)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .count    (count_ff),
         .prev_rec ((g == 0) ? new_rec : rec_w[(g == 0) ? 0 : g - 1]),
         .upd      (upd_w[g]),
         .rec      (rec_w[g]),
         .match    (match_w[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         sel_ff       <= '0;
         status_ff    <= STATUS_OK;
         has_rec_ff   <= 1'b0;
      end else begin
         if (state_ff == ST_LOAD && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_ch.valid) begin
                  req_ff   <= req_ch.data;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               unique case (req_ff.mode)
                  MODE_ADD: begin
                     state_ff <= ST_LOAD;
                     if (full) begin
                        status_ff  <= STATUS_FULL;
                        has_rec_ff <= 1'b0;
                     end else begin
                        status_ff  <= STATUS_OK;
                        count_ff   <= count_ff + CNT_W'(1);
                        sel_ff     <= ENTRIES'(1);
                        has_rec_ff <= 1'b1;
                     end
                  end
                  MODE_HIT: begin
                     state_ff <= ST_SEL;
                  end
                  MODE_READ: begin
                     state_ff <= ST_LOAD;
                     if (slot_ok) begin
                        status_ff  <= STATUS_OK;
                        sel_ff     <= slot_sel;
                        has_rec_ff <= 1'b1;
                     end else begin
                        status_ff  <= STATUS_BEYOND;
                        has_rec_ff <= 1'b0;
                     end
                  end
                  default: begin
                     state_ff   <= ST_LOAD;
                     status_ff  <= STATUS_OK;
                     has_rec_ff <= 1'b0;
                     count_ff   <= '0;
                  end
               endcase
            end
            ST_SEL: begin
               sel_ff     <= first_w;
               has_rec_ff <= any_match;
               status_ff  <= any_match ? STATUS_OK : STATUS_NOT_FOUND;
               state_ff   <= ST_LOAD;
            end
            default: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
         endcase
      end
      if (state_ff == ST_LOAD && out_free) begin
         rsp_data_ff.status       <= status_ff;
         rsp_data_ff.out_protocol <= rd_rec.protocol;
         rsp_data_ff.out_action   <= rd_rec.action;
         rsp_data_ff.out_hook     <= rd_rec.hook;
         rsp_data_ff.out_src_addr <= rd_rec.src_addr;
         rsp_data_ff.out_dst_addr <= rd_rec.dst_addr;
         rsp_data_ff.out_sport    <= rd_rec.sport;
         rsp_data_ff.out_dport    <= rd_rec.dport;
         rsp_data_ff.out_why      <= rd_rec.why;
         rsp_data_ff.out_hits     <= rd_rec.hits;
         rsp_data_ff.out_time     <= rd_rec.stamp;
         rsp_data_ff.used         <= USED_W'(count_ff);
      end
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

endmodule

`default_nettype wire

[src/bfhc_checker.sv]
// ----------------------------------------------------------------------------
// bfhc_checker
// Port-level checks for the flow hit counter table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bfhc_checker #(
   parameter int ENTRIES = bfhc_pkg::ENTRIES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  bfhc_pkg::rsp_type rsp_data
);
   import bfhc_pkg::*;

   // held response stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // one request in flight
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_FULL |-> rsp_data.used == USED_W'(ENTRIES))
      else $error("full reported below capacity");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_NOT_FOUND || rsp_data.status == STATUS_BEYOND)
      |-> rsp_data.out_hits == 32'd0 && rsp_data.out_time == 32'd0)
      else $error("record fields set on a miss");

   a_clear_used: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_OK && rsp_data.out_hits == 32'd0 &&
      rsp_data.out_time == 32'd0 && rsp_data.out_src_addr == 32'd0 &&
      rsp_data.used == '0 |-> rsp_data.out_protocol == 8'd0)
      else $error("empty table returned a record");

endmodule

bind bidirectional_flow_hit_counter bfhc_checker #(.ENTRIES(ENTRIES)) u_bfhc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  (rsp_ch.data)
);

`default_nettype wire
